@@ rtl/pitch_scale_quantizer_core_assert.svh @@
// Assertion macros for the checker module of the pitch scale quantizer.
`ifndef PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH
`define PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define PSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pitch scale quantizer check failed");

// Next-cycle implication, sampled on clk, off while reset is low.
`define PSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pitch scale quantizer check failed");

`endif

@@ rtl/psq_pkg.sv @@
// Shared constants, types and a helper function of the pitch scale quantizer.
`default_nettype none

package psq_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned X_W      = 11;  // sample plus one
  localparam int unsigned MASK_W   = 12;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned NOTE_W   = 4;
  localparam int unsigned SEMI_W   = 7;   // semitone 0..120

  // Quantizer constants
  localparam logic [X_W-1:0]    HYST_LIMIT  = 11'd4;
  localparam logic [11:0]       STEP_OFFSET = 12'd8;
  localparam logic [7:0]        DIV17_MUL   = 8'd241;  // 241/4096 ~ 1/17
  localparam logic [5:0]        DIV12_MUL   = 6'd43;   // 43/512 ~ 1/12
  localparam logic [NOTE_W-1:0] NOTES_PER_OCT = 4'd12;
  localparam logic [NOTE_W-1:0] EMPTY_NOTE  = 4'd12;
  localparam logic [CODE_W-1:0] CODE_MAX    = 8'd255;
  localparam logic [MASK_W-1:0] MASK_RESET  = 12'hFFF;

  // Quantizer result
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [NOTE_W-1:0] note;
  } psq_quant_t;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [NOTE_W-1:0] psq_first_set(input logic [MASK_W-1:0] bits);
    logic [NOTE_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = NOTE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pitch_scale_quantizer_core.sv @@
// Top level of the pitch scale quantizer: input stage, held state and output word.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 10-bit converter sample per word.
//   Output channel (out_valid/out_ready) returns one word per sample: the held
//   DAC code, a code-changed flag, the held note (12 = empty scale) and a flag
//   that says whether the sample cleared the hysteresis window.
//   cfg_wr_en/cfg_wr_data write the 12-bit scale mask; change it only while idle.
// Pipeline:
//   An accepted sample passes one input register, then the quantizer logic into
//   the output register. Throughput is one word per cycle unless the output stalls;
//   the held state updates as a word moves into the output register, so the next
//   sample already sees it.
// Reset (rst_n low, synchronous): both stages empty, held input/code/note zero,
//   scale mask all ones.
// Stall: when out_ready is low the output word holds; the input register keeps
//   one more word, and in_ready drops once both stages are full.
`default_nettype none

module pitch_scale_quantizer_core
  import psq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_adc_sample,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CODE_W-1:0]        out_dac_code,
  output logic                     out_code_changed,
  output logic [NOTE_W-1:0]        out_note_shown,
  output logic                     out_note_refreshed,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [MASK_W-1:0]   cfg_wr_data
);

  logic              s1_valid_r;
  logic [X_W-1:0]    s1_x_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_changed_r;
  logic [NOTE_W-1:0] out_note_r;
  logic              out_refreshed_r;
  logic [MASK_W-1:0] scale_mask_r;
  logic [X_W-1:0]    held_input_r;
  logic [CODE_W-1:0] held_code_r;
  logic [NOTE_W-1:0] held_note_r;

  logic              advance;
  logic              in_fire;
  logic [X_W-1:0]    diff;
  logic              passed;
  logic              code_diff;
  psq_quant_t        quant;
  logic [X_W-1:0]    held_input_nxt;
  logic [CODE_W-1:0] held_code_nxt;
  logic [NOTE_W-1:0] held_note_nxt;
  logic              changed_nxt;

  // Handshake
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  psq_quant u_quant (
    .x          (s1_x_r),
    .scale_mask (scale_mask_r),
    .result     (quant)
  );

  // Hysteresis window against the held input
  assign diff   = (s1_x_r > held_input_r) ? (s1_x_r - held_input_r) : (held_input_r - s1_x_r);
  assign passed = diff > HYST_LIMIT;
  assign code_diff = quant.code != held_code_r;

  // Next held state
  always_comb begin
    held_input_nxt = held_input_r;
    held_code_nxt  = held_code_r;
    held_note_nxt  = held_note_r;
    changed_nxt    = 1'b0;
    if (passed) begin
      held_note_nxt = quant.note;
      if (code_diff) begin
        held_input_nxt = s1_x_r;
        held_code_nxt  = quant.code;
        changed_nxt    = 1'b1;
      end
    end
  end

  // Control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      scale_mask_r <= MASK_RESET;
      held_input_r <= '0;
      held_code_r  <= '0;
      held_note_r  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        held_input_r <= held_input_nxt;
        held_code_r  <= held_code_nxt;
        held_note_r  <= held_note_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        scale_mask_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r <= {1'b0, in_adc_sample} + 11'd1;
    end
    if (advance) begin
      out_code_r      <= held_code_nxt;
      out_changed_r   <= changed_nxt;
      out_note_r      <= held_note_nxt;
      out_refreshed_r <= passed;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dac_code       = out_code_r;
  assign out_code_changed   = out_changed_r;
  assign out_note_shown     = out_note_r;
  assign out_note_refreshed = out_refreshed_r;

endmodule

`default_nettype wire

@@ rtl/psq_quant.sv @@
// Combinational quantizer: sample to semitone, scale search and output code.
`default_nettype none

module psq_quant
  import psq_pkg::*;
(
  input  wire logic [X_W-1:0]    x,
  input  wire logic [MASK_W-1:0] scale_mask,
  output psq_quant_t             result
);

  logic [11:0]         step_w;
  logic [19:0]         div17_prod;
  logic [SEMI_W-1:0]   semi;
  logic [12:0]         div12_prod;
  logic [NOTE_W-1:0]   octave;
  logic [SEMI_W-1:0]   oct_x12;
  logic [NOTE_W-1:0]   note_base;
  logic [2*MASK_W-1:0] mask_rot;
  logic [NOTE_W-1:0]   step_up;
  logic [4:0]          note_sum;
  logic [CODE_W-1:0]   semi_final;
  logic [CODE_W:0]     code_dbl;

  // Semitone = (2x + 8) / 17 by reciprocal multiply
  assign step_w     = {x, 1'b0} + STEP_OFFSET;
  assign div17_prod = step_w * DIV17_MUL;
  assign semi       = div17_prod[18:12];

  // Note within octave = semi mod 12
  assign div12_prod = semi * DIV12_MUL;
  assign octave     = div12_prod[12:9];
  assign oct_x12    = SEMI_W'({3'b000, octave} * 7'd12);
  assign note_base  = NOTE_W'(semi - oct_x12);

  // Rotate the mask so the current note sits at bit 0, then find the first enabled
  assign mask_rot = {scale_mask, scale_mask} >> note_base;
  assign step_up  = psq_first_set(mask_rot[MASK_W-1:0]);

  // Wrapped note and final semitone
  assign note_sum   = {1'b0, note_base} + {1'b0, step_up};
  assign semi_final = {1'b0, semi} + {4'b0000, step_up};
  assign code_dbl   = {semi_final, 1'b0};

  always_comb begin
    if (scale_mask == '0) begin
      result.code = '0;
      result.note = EMPTY_NOTE;
    end else begin
      result.code = (code_dbl > {1'b0, CODE_MAX}) ? CODE_MAX : code_dbl[CODE_W-1:0];
      if (note_sum >= {1'b0, NOTES_PER_OCT}) begin
        result.note = NOTE_W'(note_sum - {1'b0, NOTES_PER_OCT});
      end else begin
        result.note = note_sum[NOTE_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/psq_checker.sv @@
// Port-level checker for the pitch scale quantizer, bound to the top level.
`default_nettype none
`include "pitch_scale_quantizer_core_assert.svh"

module psq_checker
  import psq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CODE_W-1:0] out_dac_code,
  input wire logic              out_code_changed,
  input wire logic [NOTE_W-1:0] out_note_shown,
  input wire logic              out_note_refreshed
);

  // A stalled output word holds
  `PSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_dac_code) && $stable(out_note_shown))

  // A code update only comes from a quantizer pass
  `PSQ_ASSERT_NOW(a_change_needs_refresh, out_valid && out_code_changed, out_note_refreshed)

  // Note is 0..11 or the empty-scale mark
  `PSQ_ASSERT_NOW(a_note_range, out_valid, out_note_shown <= EMPTY_NOTE)

  // Empty scale always pairs with code zero
  `PSQ_ASSERT_NOW(a_empty_code, out_valid && out_note_shown == EMPTY_NOTE, out_dac_code == '0)

  // Code is twice a semitone unless saturated
  `PSQ_ASSERT_NOW(a_code_even, out_valid, !out_dac_code[0] || out_dac_code == CODE_MAX)

endmodule

bind pitch_scale_quantizer_core psq_checker u_psq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_dac_code       (out_dac_code),
  .out_code_changed   (out_code_changed),
  .out_note_shown     (out_note_shown),
  .out_note_refreshed (out_note_refreshed)
);

`default_nettype wire

@@ tb/pitch_scale_quantizer_core_tb.sv @@
// Self-checking testbench for pitch_scale_quantizer_core: directed table, then random phases.
`default_nettype none

module pitch_scale_quantizer_core_tb
  import psq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEMI_DIVISOR = 17;
  localparam int WORDS_PER_PHASE = 175;
  localparam int PHASES = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // One output word
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              changed;
    logic [NOTE_W-1:0] note;
    logic              refreshed;
  } quant_word_t;

  // One row of the directed table
  typedef struct {
    bit                  load_mask;
    logic [MASK_W-1:0]   mask;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    quant_word_t         want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_adc_sample;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CODE_W-1:0]   out_dac_code;
  logic                out_code_changed;
  logic [NOTE_W-1:0]   out_note_shown;
  logic                out_note_refreshed;
  logic                cfg_wr_en;
  logic [MASK_W-1:0]   cfg_wr_data;

  pitch_scale_quantizer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dac_code      (out_dac_code),
    .out_code_changed  (out_code_changed),
    .out_note_shown    (out_note_shown),
    .out_note_refreshed(out_note_refreshed),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // Predictor state: scale mask and held input/code/note
  logic [MASK_W-1:0] scale_bits = MASK_RESET;
  logic [X_W-1:0]    last_x     = '0;
  logic [CODE_W-1:0] last_code  = '0;
  logic [NOTE_W-1:0] last_note  = '0;

  quant_word_t quant_words_due[$];
  stim_row_t   stim_rows[$];
  int          mismatch_count = 0;
  int          send_gap_pct   = 0;
  int          stall_pct      = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Hysteresis check, then semitone, scale search and saturation
  function automatic quant_word_t quantize_sample(input logic [SAMPLE_W-1:0] s);
    logic [X_W-1:0] x;
    logic [X_W-1:0] delta;
    int             semi;
    int             octave;
    int             pos;
    int             step;
    int             q;
    quant_word_t    w;
    x = X_W'(s) + 11'd1;
    delta = (x > last_x) ? x - last_x : last_x - x;
    w.changed = 1'b0;
    w.refreshed = 1'b0;
    if (delta > HYST_LIMIT) begin
      w.refreshed = 1'b1;
      if (scale_bits == '0) begin
        q = 0;
        pos = int'(EMPTY_NOTE);
      end else begin
        semi = (2 * int'(x) + int'(STEP_OFFSET)) / SEMI_DIVISOR;
        octave = semi / int'(NOTES_PER_OCT);
        pos = semi % int'(NOTES_PER_OCT);
        step = 0;
        while (!scale_bits[(pos + step) % int'(NOTES_PER_OCT)]) step++;
        pos += step;
        // wrapped past B into the next octave
        if (pos >= int'(NOTES_PER_OCT)) begin
          pos -= int'(NOTES_PER_OCT);
          octave++;
        end
        q = (octave * int'(NOTES_PER_OCT) + pos) * 2;
        if (q > int'(CODE_MAX)) q = int'(CODE_MAX);
      end
      last_note = NOTE_W'(pos);
      // held input only moves with the code
      if (CODE_W'(q) != last_code) begin
        last_x = x;
        last_code = CODE_W'(q);
        w.changed = 1'b1;
      end
    end
    w.code = last_code;
    w.note = last_note;
    return w;
  endfunction

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d, want %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input bit load, input logic [MASK_W-1:0] m,
                         input logic [SAMPLE_W-1:0] s, input bit typed,
                         input int code, input int changed, input int note,
                         input int refreshed);
    stim_row_t r;
    r.load_mask = load;
    r.mask = m;
    r.sample = s;
    r.typed = typed;
    r.want.code = CODE_W'(code);
    r.want.changed = 1'(changed);
    r.want.note = NOTE_W'(note);
    r.want.refreshed = 1'(refreshed);
    stim_rows.push_back(r);
  endtask

  // Hold the sender off until every due word has come out; called at a falling edge
  task automatic drain_words();
    in_valid = 1'b0;
    while (quant_words_due.size() != 0) @(negedge clk);
  endtask

  // Mask write while the block is idle
  task automatic write_scale(input logic [MASK_W-1:0] m);
    drain_words();
    repeat (3) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wr_data = MASK_W'($urandom_range(0, 4095));
    scale_bits = m;
  endtask

  // Offer one sample word; entered and left at a falling edge
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input quant_word_t want);
    quant_word_t w;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      in_adc_sample = SAMPLE_W'($urandom_range(0, 1023));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_adc_sample = s;
    do @(posedge clk); while (!in_ready);
    w = quantize_sample(s);
    quant_words_due.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Output word check against the oldest due word
  always @(posedge clk) begin
    quant_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (quant_words_due.size() == 0) begin
        flag_mismatch("unexpected word, code", int'(out_dac_code), -1);
      end else begin
        want = quant_words_due.pop_front();
        if (out_dac_code !== want.code)
          flag_mismatch("dac_code", int'(out_dac_code), int'(want.code));
        if (out_code_changed !== want.changed)
          flag_mismatch("code_changed", int'(out_code_changed), int'(want.changed));
        if (out_note_shown !== want.note)
          flag_mismatch("note_shown", int'(out_note_shown), int'(want.note));
        if (out_note_refreshed !== want.refreshed)
          flag_mismatch("note_refreshed", int'(out_note_refreshed), int'(want.refreshed));
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] prev;
    logic [MASK_W-1:0]   m;
    quant_word_t         none;
    int                  r;
    int                  v;
    none = '0;
    prev = '0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: typed rows where the answer is plain, the rest predicted
    add_row(0, 0, 10'd0, 1, 0, 0, 0, 0);          // within window of reset state
    add_row(0, 0, 10'd3, 1, 0, 0, 0, 0);          // window edge, distance 4
    add_row(0, 0, 10'd4, 1, 2, 1, 1, 1);          // distance 5, first update
    add_row(0, 0, 10'd1023, 1, 240, 1, 0, 1);     // top of range, full scale
    add_row(0, 0, 10'd1020, 1, 240, 0, 0, 0);     // inside window again
    add_row(0, 0, 10'd1018, 1, 240, 0, 0, 1);     // requantized, same code
    add_row(0, 0, 10'd0, 1, 0, 1, 0, 1);          // bottom of range
    add_row(1, 12'h000, 10'd500, 1, 0, 0, int'(EMPTY_NOTE), 1);   // empty scale
    add_row(0, 0, 10'd1023, 1, 0, 0, int'(EMPTY_NOTE), 1);
    add_row(1, 12'h800, 10'd1023, 1, 255, 1, 11, 1);              // only B, saturates
    add_row(0, 0, 10'd1022, 0, 0, 0, 0, 0);
    add_row(1, 12'h001, 10'd100, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd101, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd600, 0, 0, 0, 0, 0);
    add_row(1, 12'hA5A, 10'd300, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd5, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd1000, 0, 0, 0, 0, 0);
    add_row(1, MASK_RESET, 10'd511, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd512, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd1023, 0, 0, 0, 0, 0);
    add_row(0, 0, 10'd514, 0, 0, 0, 0, 0);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].load_mask) write_scale(stim_rows[i].mask);
      offer_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].want);
      prev = stim_rows[i].sample;
    end

    // Random phases; each writes a mask and sets one of four idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_words();
      case (idle_mode_t'(ph % 4))
        IDLE_NONE: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_gap_pct = 83;
          stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_gap_pct = 0;
          stall_pct = 83;
        end
        default: begin
          send_gap_pct = 6;
          stall_pct = 6;
        end
      endcase
      case (ph % 4)
        1: m = MASK_W'(1) << $urandom_range(0, 11);
        2: m = (ph < 4) ? MASK_RESET : '0;
        default: m = MASK_W'($urandom_range(0, 4095));
      endcase
      write_scale(m);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          v = $urandom_range(0, 1023);
        end else if (r < 80) begin
          // small moves around the last sample probe the hysteresis window
          v = int'(prev) + int'($urandom_range(0, 16)) - 8;
        end else if (r < 90) begin
          v = $urandom_range(0, 15);
        end else begin
          v = $urandom_range(1008, 1023);
        end
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        s = SAMPLE_W'(v);
        if ($urandom_range(0, 199) == 0) drain_words();
        offer_sample(s, 1'b0, none);
        prev = s;
      end
    end

    drain_words();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
